// ===== rtl/ppt_pkg.sv =====
// ----------------------------------------------------------------------------
// ppt_pkg
// Types, operation codes and the edge crossing test shared by the
// point-in-polygon tester and its cells.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int COORD_W    = 16;
  localparam int HELD_W     = 6;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic              inside_res;
    logic              overflowed;
    logic [HELD_W-1:0] vertices_held;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  // Query state handed from cell to cell.
  typedef struct packed {
    logic    valid;
    logic    ovf;
    logic    parity;
    vertex_t pt;
    vertex_t first;
    vertex_t prev;
  } token_t;

  // Edge from vj to vi; true when the crossing count toggles for point p.
  function automatic logic edge_toggles(vertex_t vi, vertex_t vj, vertex_t p);
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dz;
    logic signed [DIFF_W-1:0] rz;
    logic signed [DIFF_W-1:0] ex;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
    logic signed [SUM_W-1:0]  s;
    logic                     dz_pos;
    logic                     dz_zero;
    logic                     tog;
    dx = DIFF_W'(vj.x) - DIFF_W'(vi.x);
    dz = DIFF_W'(vj.z) - DIFF_W'(vi.z);
    rz = DIFF_W'(p.z) - DIFF_W'(vi.z);
    ex = DIFF_W'(vi.x) - DIFF_W'(p.x);
    p1 = PROD_W'(ex) * PROD_W'(dz);
    p2 = PROD_W'(dx) * PROD_W'(rz);
    s  = SUM_W'(p1) + SUM_W'(p2);
    dz_zero = (dz == '0);
    dz_pos  = !dz[DIFF_W-1] && !dz_zero;
    if (dz_zero) begin
      tog = 1'b0;
    end else if (dz_pos) begin
      tog = !rz[DIFF_W-1] && (rz < dz) && !s[SUM_W-1];
    end else begin
      // Span runs downward: z_j < pz <= z_i, and the sign test flips.
      tog = (rz[DIFF_W-1] || (rz == '0)) && (rz > dz) &&
            (s[SUM_W-1] || (s == '0));
    end
    return tog;
  endfunction

endpackage

// ===== rtl/ppt_cell.sv =====
// ----------------------------------------------------------------------------
// ppt_cell
// One vertex slot of the chain. Holds its vertex, tests the edge from the
// previous vertex carried by the passing query, and forwards the query.
// ----------------------------------------------------------------------------
module ppt_cell
  import ppt_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             wr_en,
  input  logic [CNT_W-1:0] wr_idx,
  input  vertex_t          wr_vertex,
  input  token_t           tok_in,
  input  logic [CNT_W-1:0] cnt_in,
  output token_t           tok_out,
  output logic [CNT_W-1:0] cnt_out
);

  vertex_t vertex;
  token_t  tok_next;
  logic    active;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == CNT_W'(INDEX))) begin
      vertex <= wr_vertex;
    end
  end

  assign active = tok_in.valid && (CNT_W'(INDEX) < cnt_in);

  generate
    if (INDEX == 0) begin : g_head
      // The first vertex opens the walk; its closing edge is tested at the end.
      always_comb begin
        tok_next = tok_in;
        if (active) begin
          tok_next.first = vertex;
          tok_next.prev  = vertex;
        end
      end
    end else begin : g_body
      always_comb begin
        tok_next = tok_in;
        if (active) begin
          tok_next.parity = tok_in.parity ^ edge_toggles(vertex, tok_in.prev, tok_in.pt);
          tok_next.prev   = vertex;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
      cnt_out <= cnt_in;
    end
  end

endmodule

// ===== rtl/point_in_polygon_tester.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_tester
// Crossing-number point-in-polygon test over a stored polygon. Vertices live
// in a chain of cells; a query walks it one cell per cycle while it advances.
//
//   channel  | signals                          | payload
//   ---------+----------------------------------+-------------------------
//   input    | item_valid / item_ready / item   | operation, coord_x, coord_z
//   output   | result_valid / result_ready      | inside_res, overflowed,
//            |   / result                       |   vertices_held
//
// One item is taken per cycle whenever the chain advances. A query enters the
// first cell at the edge that takes it, moves one cell per cycle while the
// chain advances, and the output register, which also tests the closing
// edge, holds its result. Clear and append items finish in the cycle they
// are taken and give no result. The whole chain, and so item_ready, holds
// while a result waits on result_ready.
// Reset empties the chain and clears the vertex count and overflow flag.
// ----------------------------------------------------------------------------
module point_in_polygon_tester
  import ppt_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [CNT_W-1:0] vertex_count;
  logic             overflow_flag;
  logic             advance;
  logic             accept;
  logic             full;
  logic             wr_en;
  vertex_t          wr_vertex;
  logic             close_tog;

  token_t           tok [MAX_VERTICES+1];
  logic [CNT_W-1:0] cnt [MAX_VERTICES+1];

  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;
  assign accept     = item_valid && item_ready;
  assign full       = (vertex_count == CNT_W'(MAX_VERTICES));
  assign wr_en      = accept && (item.operation == OP_APPEND) && !full;
  assign wr_vertex  = '{x: item.coord_x, z: item.coord_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      unique case (item.operation)
        OP_CLEAR: begin
          vertex_count  <= '0;
          overflow_flag <= 1'b0;
        end
        OP_APPEND: begin
          if (full) begin
            overflow_flag <= 1'b1;
          end else begin
            vertex_count <= vertex_count + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A query enters the chain with the count and flag as they stand now.
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = accept && (item.operation == OP_QUERY);
    tok[0].ovf    = overflow_flag;
    tok[0].pt     = wr_vertex;
    cnt[0]        = vertex_count;
  end

  generate
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
      ppt_cell #(
        .INDEX (k),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .wr_en     (wr_en),
        .wr_idx    (vertex_count),
        .wr_vertex (wr_vertex),
        .tok_in    (tok[k]),
        .cnt_in    (cnt[k]),
        .tok_out   (tok[k+1]),
        .cnt_out   (cnt[k+1])
      );
    end
  endgenerate

  // Closing edge runs from the last stored vertex back to the first.
  assign close_tog = (cnt[MAX_VERTICES] != '0) &&
                     edge_toggles(tok[MAX_VERTICES].first, tok[MAX_VERTICES].prev,
                                  tok[MAX_VERTICES].pt);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= tok[MAX_VERTICES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.inside_res    <= tok[MAX_VERTICES].parity ^ close_tog;
      result.overflowed    <= tok[MAX_VERTICES].ovf;
      result.vertices_held <= HELD_W'(cnt[MAX_VERTICES]);
    end
  end

endmodule

// ===== rtl/ppt_checker.sv =====
// ----------------------------------------------------------------------------
// ppt_checker
// Port-level checks for the point-in-polygon tester, bound to the top level.
// ----------------------------------------------------------------------------
module ppt_checker
  import ppt_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input logic      clk,
  input logic      rst,
  input logic      item_ready,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  // A waiting result must not change.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // The input side only stops when a result is stuck on the output.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("item_ready low without an output stall");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(result.vertices_held) <= MAX_VERTICES))
    else $error("vertices_held beyond capacity");

  // With fewer than two vertices no edge can toggle the crossing count.
  a_degenerate: assert property (@(posedge clk) disable iff (rst)
    result_valid && (MAX_VERTICES < 64) &&
    (result.vertices_held < HELD_W'(2)) |-> !result.inside_res)
    else $error("inside reported for a degenerate polygon");

endmodule

bind point_in_polygon_tester ppt_checker #(
  .MAX_VERTICES (MAX_VERTICES)
) u_ppt_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== dv/tb_point_in_polygon_tester.sv =====
// ----------------------------------------------------------------------------
// tb_point_in_polygon_tester
// Self-checking bench for the point-in-polygon tester. A directed table covers
// the empty store, the single vertex, the extreme coordinates, overflow of the
// store and the clear item. Random polygons with random queries follow. Every
// query result is checked, field by field, against a typed answer from the
// directed table or an in-bench model of the store and crossing-number test.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_tester;
  import ppt_pkg::*;

  localparam int NV         = 32;
  localparam int CYCLE_CAP  = 500_000;
  localparam int ITEM_GOAL  = 700;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] CMIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] CMAX = 16'sh7fff;

  typedef struct {
    in_item_t  stim;
    int        reps;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  // Model of the vertex store.
  logic signed [COORD_W-1:0] poly_x [NV];
  logic signed [COORD_W-1:0] poly_z [NV];
  int unsigned               poly_count = 0;
  bit                        poly_lost = 1'b0;

  out_item_t pending_answers [$];
  stim_row_t directed_rows [$];
  int        mismatches = 0;
  int        answers_checked = 0;
  int        answers_inside = 0;
  int        answers_overflowed = 0;
  int        items_sent = 0;
  int        cycles = 0;
  int        ready_hold = 0;
  bit        calm = 1'b0;

  point_in_polygon_tester #(
    .MAX_VERTICES(NV)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Crossing test for the edge running from vertex j to vertex i.
  function automatic bit edge_crossed(longint xi, longint zi, longint xj, longint zj,
                                      longint px, longint pz);
    longint dx;
    longint dz;
    longint rz;
    longint s;
    dx = xj - xi;
    dz = zj - zi;
    rz = pz - zi;
    s  = (xi - px) * dz + dx * rz;
    if (dz == 0) begin
      return 1'b0;
    end else if (dz > 0) begin
      return (rz >= 0) && (rz < dz) && (s >= 0);
    end else begin
      return (rz <= 0) && (rz > dz) && (s <= 0);
    end
  endfunction

  // Applies one item to the store model; returns 1 when it yields an answer.
  function automatic bit polygon_step(in_item_t it, output out_item_t answer);
    bit          parity;
    int unsigned j;
    answer = '0;
    case (it.operation)
      OP_CLEAR: begin
        poly_count = 0;
        poly_lost  = 1'b0;
        return 1'b0;
      end
      OP_APPEND: begin
        if (poly_count >= NV) begin
          poly_lost = 1'b1;
        end else begin
          poly_x[poly_count] = it.coord_x;
          poly_z[poly_count] = it.coord_z;
          poly_count++;
        end
        return 1'b0;
      end
      OP_QUERY: begin
        parity = 1'b0;
        if (poly_count > 0) begin
          j = poly_count - 1;
          for (int unsigned i = 0; i < poly_count; i++) begin
            if (edge_crossed(poly_x[i], poly_z[i], poly_x[j], poly_z[j],
                             it.coord_x, it.coord_z)) begin
              parity = ~parity;
            end
            j = i;
          end
        end
        answer.inside_res    = parity;
        answer.overflowed    = poly_lost;
        answer.vertices_held = HELD_W'(poly_count);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] near(int centre, int span);
    return COORD_W'(centre + int'($urandom_range(0, span)) - span / 2);
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] z);
    in_item_t it;
    it.operation = op;
    it.coord_x   = x;
    it.coord_z   = z;
    return it;
  endfunction

  task automatic add_row(logic [1:0] op, logic signed [COORD_W-1:0] x,
                         logic signed [COORD_W-1:0] z, int reps, bit typed,
                         out_item_t want);
    stim_row_t row;
    row.stim  = make_item(op, x, z);
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offers one item and books its answer once the block takes it.
  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    int        gap;
    out_item_t answer;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    if (it.operation != OP_UNUSED) begin
      items_sent++;
    end
    if (polygon_step(it, answer)) begin
      pending_answers.insert(pending_answers.size(), typed ? want : answer);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls: mostly short, now and then long.
  always @(posedge clk) begin : ready_gen
    int r;
    if (calm) begin
      result_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        result_ready <= 1'b1;
        ready_hold   <= $urandom_range(0, 4);
      end else if (r < 92) begin
        result_ready <= 1'b0;
        ready_hold   <= $urandom_range(0, 3);
      end else begin
        result_ready <= 1'b0;
        ready_hold   <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin : answer_check
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with no query outstanding: %p", $time, result);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (result.inside_res) answers_inside++;
        if (result.overflowed) answers_overflowed++;
        if (result.inside_res !== want.inside_res) begin
          $display("%0t: inside_res expected %0b, got %0b", $time,
                   want.inside_res, result.inside_res);
          mismatches++;
        end
        if (result.overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %0b, got %0b", $time,
                   want.overflowed, result.overflowed);
          mismatches++;
        end
        if (result.vertices_held !== want.vertices_held) begin
          $display("%0t: vertices_held expected %0d, got %0d", $time,
                   want.vertices_held, result.vertices_held);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycles,
               pending_answers.size());
      $display("tb_point_in_polygon_tester: errors");
      $finish;
    end
  end

  initial begin
    vertex_t     shape [$];
    int          n_verts;
    int          n_queries;
    int          span;
    int          bx;
    int          bz;
    int          r;
    int          pick;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qz;
    vertex_t     v;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table; typed answers are the ones obvious without computing.
    add_row(OP_QUERY,  16'sh0000, 16'sh0000, 1, 1'b1, '{1'b0, 1'b0, 6'd0});
    add_row(OP_UNUSED, CMAX,      CMIN,      1, 1'b0, '0);
    add_row(OP_APPEND, CMIN,      CMIN,      1, 1'b0, '0);
    add_row(OP_QUERY,  CMAX,      CMAX,      1, 1'b1, '{1'b0, 1'b0, 6'd1});
    add_row(OP_APPEND, CMAX,      CMIN,      1, 1'b0, '0);
    add_row(OP_APPEND, CMAX,      CMAX,      1, 1'b0, '0);
    add_row(OP_APPEND, CMIN,      CMAX,      1, 1'b0, '0);
    add_row(OP_QUERY,  16'sh0000, 16'sh0000, 1, 1'b0, '0);
    add_row(OP_QUERY,  CMIN,      CMIN,      1, 1'b0, '0);
    add_row(OP_QUERY,  CMAX,      16'sh0000, 1, 1'b0, '0);
    add_row(OP_QUERY,  CMIN,      CMAX,      1, 1'b0, '0);
    add_row(OP_QUERY,  16'shffff, 16'sh0001, 1, 1'b0, '0);
    // Fills the store and pushes one vertex past its end.
    add_row(OP_APPEND, 16'sh0100, 16'sh0100, 29, 1'b0, '0);
    add_row(OP_QUERY,  16'sh0000, 16'sh0000, 1, 1'b0, '0);
    add_row(OP_QUERY,  CMAX,      CMIN,      1, 1'b0, '0);
    add_row(OP_CLEAR,  CMAX,      CMAX,      1, 1'b0, '0);
    add_row(OP_QUERY,  16'sh0000, 16'sh0000, 1, 1'b1, '{1'b0, 1'b0, 6'd0});
    add_row(OP_APPEND, 16'sh0100, 16'sh0000, 1, 1'b0, '0);
    add_row(OP_APPEND, 16'shff00, 16'sh0200, 1, 1'b0, '0);
    add_row(OP_QUERY,  16'sh0000, 16'sh0100, 1, 1'b0, '0);
    add_row(OP_APPEND, 16'sh0000, 16'shfe00, 1, 1'b0, '0);
    add_row(OP_QUERY,  16'sh0000, 16'sh0000, 1, 1'b0, '0);
    add_row(OP_QUERY,  16'sh0100, 16'sh0000, 1, 1'b0, '0);

    foreach (directed_rows[k]) begin
      repeat (directed_rows[k].reps) begin
        send_item(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);
      end
    end
    drain();

    while (items_sent < ITEM_GOAL) begin
      calm = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        // Noise: any operation, any coordinates.
        repeat ($urandom_range(2, 8)) begin
          send_item(make_item(2'($urandom_range(0, 3)), COORD_W'($urandom()),
                              COORD_W'($urandom())));
        end
      end else begin
        pick = $urandom_range(0, 2);
        span = (pick == 0) ? 64 : (pick == 1) ? 1024 : 65535;
        bx   = int'($urandom_range(0, 65535)) - 32768;
        bz   = int'($urandom_range(0, 65535)) - 32768;
        pick = $urandom_range(0, 9);
        n_verts = (pick < 7) ? $urandom_range(3, 10) :
                  (pick < 9) ? $urandom_range(11, 31) : $urandom_range(32, 36);
        shape.delete();
        if ($urandom_range(0, 4) != 0) begin
          send_item(make_item(OP_CLEAR, COORD_W'($urandom()), COORD_W'($urandom())));
        end
        repeat (n_verts) begin
          v.x = near(bx, span);
          v.z = near(bz, span);
          shape.insert(shape.size(), v);
          send_item(make_item(OP_APPEND, v.x, v.z));
          // A sequence broken by a stray query or an unused code.
          if ($urandom_range(0, 19) == 0) begin
            send_item(make_item(($urandom_range(0, 1) != 0) ? OP_QUERY : OP_UNUSED,
                                near(bx, span), near(bz, span)));
          end
        end
        n_queries = $urandom_range(2, 8);
        repeat (n_queries) begin
          v    = shape[$urandom_range(0, shape.size() - 1)];
          pick = $urandom_range(0, 9);
          qx   = near(bx, span + span / 4);
          qz   = near(bz, span + span / 4);
          if (pick < 3) begin
            qz = v.z;
          end else if (pick == 3) begin
            qx = v.x;
            qz = v.z;
          end else if (pick == 4) begin
            qx = v.x;
          end
          send_item(make_item(OP_QUERY, qx, qz));
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        drain();
      end
    end

    calm = 1'b0;
    drain();
    repeat (NV + 8) @(posedge clk);

    $display("checked %0d query answers from %0d items; %0d inside, %0d with overflow set",
             answers_checked, items_sent, answers_inside, answers_overflowed);
    $display("polygons up to and past %0d vertices, extreme coordinates, clears mid-stream",
             NV);
    if (pending_answers.size() != 0) begin
      $display("%0t: %0d expected answers never arrived", $time, pending_answers.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_point_in_polygon_tester: clean");
    end else begin
      $display("tb_point_in_polygon_tester: errors");
    end
    $finish;
  end

endmodule
